>>> hdl/wfrm_pkg.sv
// Shared types and constants of the windowed frame rate meter.
package wfrm_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 24;
  localparam int RATE_W   = 26;

  // Largest rate the output field can carry; larger quotients saturate here.
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Microseconds in one second, the scale of the dividend.
  localparam int USEC_PER_SEC = 1000000;

  // Default number of frames in the averaging window.
  localparam int WINDOW_DEFAULT = 60;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input beat, advance the slot, read the old sample
    logic update;    // fold the new sample into the window sum, write the ring
    logic div_step;  // one restoring division step
    logic load_out;  // move the finished rate into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current step produces the last quotient bit
    logic out_full;  // the output register still holds an untaken result
  } status_t;

endpackage

>>> hdl/wfrm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wfrm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/wfrm_ctrl.sv
// Controller state machine that sequences one beat through update, division and output load.
module wfrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  wfrm_pkg::status_t status,
  output wfrm_pkg::cmd_t    cmd
);

  wfrm_pkg::state_t state;
  wfrm_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfrm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      wfrm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = wfrm_pkg::ST_UPDATE;
        end
      end
      wfrm_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = wfrm_pkg::ST_DIVIDE;
      end
      wfrm_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = wfrm_pkg::ST_FINISH;
        end
      end
      wfrm_pkg::ST_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!status.out_full || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = wfrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wfrm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/wfrm_datapath.sv
// Datapath: sample ring, running window sum, restoring divider and output register.
module wfrm_datapath #(
  parameter int WINDOW = wfrm_pkg::WINDOW_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wfrm_pkg::cmd_t              cmd,
  output wfrm_pkg::status_t           status,
  input  logic [wfrm_pkg::SAMPLE_W-1:0] frame_usec,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wfrm_pkg::RATE_W-1:0] frames_per_second
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = wfrm_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int NUM    = wfrm_pkg::USEC_PER_SEC * WINDOW;
  localparam int NUM_W  = $clog2(NUM + 1);
  localparam int CNT_W  = $clog2(NUM_W);
  localparam logic [NUM_W-1:0]  NUM_VAL  = NUM_W'(NUM);
  localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  CNT_TOP  = CNT_W'(NUM_W - 1);

  logic [wfrm_pkg::SAMPLE_W-1:0] sample;
  logic [SLOT_W-1:0]             slot;
  logic [SLOT_W-1:0]             slot_inc;
  logic [SUM_W-1:0]              sum;
  logic [WINDOW-1:0]             slot_valid;
  logic [wfrm_pkg::SAMPLE_W-1:0] ram_rd_data;
  logic [wfrm_pkg::SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]              rem;
  logic [NUM_W-1:0]              num_sh;
  logic [NUM_W-1:0]              quot;
  logic [CNT_W-1:0]              cnt;
  logic [SUM_W:0]                shifted;
  logic [SUM_W:0]                diff;
  logic                          fits;
  logic [31:0]                   quot_ext;
  logic [wfrm_pkg::RATE_W-1:0]   rate_calc;

  // Next ring slot, wrapping at the window size.
  assign slot_inc = (slot == SLOT_TOP) ? '0 : slot + 1'b1;

  // Ring storage; a slot never written since reset reads as zero.
  wfrm_ram #(
    .WIDTH (wfrm_pkg::SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (slot),
    .wr_data (sample),
    .rd_en   (cmd.capture),
    .rd_addr (slot_inc),
    .rd_data (ram_rd_data)
  );

  assign old_sample = slot_valid[slot] ? ram_rd_data : '0;

  // Control state: slot pointer, window sum, slot valid bits, output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      sum        <= '0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        slot <= slot_inc;
      end
      if (cmd.update) begin
        sum              <= sum - {{(SUM_W - wfrm_pkg::SAMPLE_W){1'b0}}, old_sample}
                                + {{(SUM_W - wfrm_pkg::SAMPLE_W){1'b0}}, sample};
        slot_valid[slot] <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // One restoring step: bring down the next dividend bit and try the divisor.
  assign shifted = {rem, num_sh[NUM_W-1]};
  assign diff    = shifted - {1'b0, sum};
  assign fits    = (shifted >= {1'b0, sum});

  // Divider registers and the captured sample.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= frame_usec;
    end
    if (cmd.update) begin
      rem    <= '0;
      num_sh <= NUM_VAL;
      quot   <= '0;
      cnt    <= '0;
    end else if (cmd.div_step) begin
      rem    <= fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      quot   <= {quot[NUM_W-2:0], fits};
      cnt    <= cnt + 1'b1;
    end
  end

  // Final rate: zero for an empty window, saturated to the field width.
  assign quot_ext = 32'(quot);
  always_comb begin
    if (sum == '0) begin
      rate_calc = '0;
    end else if (quot_ext > 32'(wfrm_pkg::RATE_MAX)) begin
      rate_calc = wfrm_pkg::RATE_MAX;
    end else begin
      rate_calc = wfrm_pkg::RATE_W'(quot);
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frames_per_second <= rate_calc;
    end
  end

  assign status.div_last = (cnt == CNT_TOP);
  assign status.out_full = out_valid;

endmodule

>>> hdl/windowed_frame_rate_meter_unit.sv
// A beat accepted in idle goes through the update state, then the restoring divider, one
// quotient bit a cycle over NUM_W bits, the width of 1000000 * WINDOW (26 bits at the
// default window), and last the finish state, which loads the output register once it is
// free or being emptied; the next beat enters only back in idle, while the result may wait.
// Reset (synchronous, active high) clears the window sum, the slot pointer, the output
// flag and one valid bit per ring slot at once, so the ring reads as all zeros.
module windowed_frame_rate_meter_unit #(
  parameter int WINDOW = wfrm_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wfrm_pkg::SAMPLE_W-1:0] frame_usec,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wfrm_pkg::RATE_W-1:0]   frames_per_second
);

  wfrm_pkg::cmd_t    cmd;
  wfrm_pkg::status_t status;

  // Sequencer.
  wfrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Ring, sum and divider.
  wfrm_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .frame_usec        (frame_usec),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .frames_per_second (frames_per_second)
  );

endmodule

>>> hdl/wfrm_checker.sv
// Port-level checks of the frame rate meter, bound to the top level.
module wfrm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wfrm_pkg::RATE_W-1:0]   frames_per_second
);

  // A stalled result beat holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frames_per_second))
    else $error("result beat changed while stalled");

  // After an input beat the block stays busy for the update and first division step.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted while a beat is still being processed");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A new result cannot appear right after an input beat; update and division come first.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early after an input beat");

endmodule

bind windowed_frame_rate_meter_unit wfrm_checker u_wfrm_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .frames_per_second (frames_per_second)
);
